>>> hw/rtl/np_pkg.sv
// Types, microcode step names and control word layout for the permutation block.
package np_pkg;

  localparam int PC_W = 5;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } np_in_t;

  typedef struct packed {
    logic [7:0] value_res;
    logic       last_res;
  } np_out_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_SHORT,
    C_ALTB,
    C_AZERO,
    C_AGEB,
    C_ALAST,
    C_OUTWAIT
  } np_cond_t;

  typedef enum logic [2:0] {
    A_KEEP,
    A_N2,
    A_ZERO,
    A_DEC,
    A_INC
  } np_aop_t;

  typedef enum logic [1:0] {
    B_KEEP,
    B_N1,
    B_DEC
  } np_bop_t;

  typedef enum logic [1:0] {
    W_NONE,
    W_AB,
    W_BH
  } np_wop_t;

  typedef struct packed {
    np_cond_t        cond;
    logic [PC_W-1:0] tgt;
    np_aop_t         a_op;
    np_bop_t         b_op;
    np_wop_t         w_op;
    logic            emit;
    logic            finish;
  } np_cw_t;

  typedef struct packed {
    logic short_seq;
    logic rd_lt;
    logic a_zero;
    logic a_ge_b;
    logic a_last;
    logic out_busy;
  } np_flags_t;

  localparam logic [PC_W-1:0] S_START  = 5'd0;
  localparam logic [PC_W-1:0] S_SWAIT  = 5'd1;
  localparam logic [PC_W-1:0] S_SCMP   = 5'd2;
  localparam logic [PC_W-1:0] S_SZERO  = 5'd3;
  localparam logic [PC_W-1:0] S_SDEC   = 5'd4;
  localparam logic [PC_W-1:0] S_REVALL = 5'd5;
  localparam logic [PC_W-1:0] S_FOUND  = 5'd6;
  localparam logic [PC_W-1:0] S_FWAIT  = 5'd7;
  localparam logic [PC_W-1:0] S_FCMP   = 5'd8;
  localparam logic [PC_W-1:0] S_FDEC   = 5'd9;
  localparam logic [PC_W-1:0] S_SWAP1  = 5'd10;
  localparam logic [PC_W-1:0] S_SWAP2  = 5'd11;
  localparam logic [PC_W-1:0] S_RCHK   = 5'd12;
  localparam logic [PC_W-1:0] S_RWAIT  = 5'd13;
  localparam logic [PC_W-1:0] S_RW1    = 5'd14;
  localparam logic [PC_W-1:0] S_RW2    = 5'd15;
  localparam logic [PC_W-1:0] S_EMIT0  = 5'd16;
  localparam logic [PC_W-1:0] S_EWAIT  = 5'd17;
  localparam logic [PC_W-1:0] S_EOUT   = 5'd18;
  localparam logic [PC_W-1:0] S_ECHK   = 5'd19;
  localparam logic [PC_W-1:0] S_EINC   = 5'd20;
  localparam logic [PC_W-1:0] S_FINISH = 5'd21;

endpackage

>>> hw/rtl/next_permutation.sv
// Top level: load, microcoded permutation datapath and result register.
//
//  channel | direction | word fields              | handshake
//  in_     | input     | value[7:0], last         | in_valid / in_stall
//  out_    | output    | value_res[7:0], last_res | out_valid / out_stall
//
// Loading accepts one word per cycle; in_stall stays low until a word with last is taken.
// After last, the program scans positions for the pivot, searches positions for the successor,
// swaps the pair, reverses the suffix pair by pair and streams the result words; its pace is
// set by the store's single write port and registered reads.
// Reset (rst_n low, synchronous) empties the sequence and clears the busy flag.
// out_stall holds the program at its output step; the result register frees a slot.
module next_permutation #(
  parameter int MAX_LEN    = 16,
  parameter int VALUE_BITS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  np_pkg::np_in_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output np_pkg::np_out_t out_data
);
  import np_pkg::*;

  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         a_r, a_nxt;
  logic [IW-1:0]         b_r, b_nxt;
  logic [VALUE_BITS-1:0] hold_r, hold_nxt;
  logic                  out_valid_r, out_valid_nxt;
  np_out_t               out_r, out_nxt;

  logic [PC_W-1:0]       pc;
  np_cw_t                cw;
  np_flags_t             flags;
  logic                  busy;
  logic                  step_en;
  logic                  in_acc;
  logic                  start;
  logic                  room;
  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         cnt_m2;
  logic [IW-1:0]         n1;
  logic [IW-1:0]         n2;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic [VALUE_BITS-1:0] rd_a;
  logic [VALUE_BITS-1:0] rd_b;

  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;
  assign start    = in_acc && in_data.last;
  assign room     = cnt_r < CW'(MAX_LEN);
  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);
  assign n1       = cnt_m1[IW-1:0];
  assign n2       = cnt_m2[IW-1:0];

  assign flags.short_seq = cnt_r < CW'(2);
  assign flags.rd_lt     = rd_a < rd_b;
  assign flags.a_zero    = a_r == '0;
  assign flags.a_ge_b    = !(a_r < b_r);
  assign flags.a_last    = a_r == n1;
  assign flags.out_busy  = out_valid_r && out_stall;

  np_rom u_rom (
    .pc (pc),
    .cw (cw)
  );

  np_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .cw      (cw),
    .flags   (flags),
    .pc      (pc),
    .busy    (busy),
    .step_en (step_en)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = a_r;
    wr_data = rd_b;
    if (in_acc && room) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r[IW-1:0];
      wr_data = VALUE_BITS'(in_data.value);
    end else if (step_en) begin
      case (cw.w_op)
        W_AB: begin
          wr_en   = 1'b1;
          wr_addr = a_r;
          wr_data = rd_b;
        end
        W_BH: begin
          wr_en   = 1'b1;
          wr_addr = b_r;
          wr_data = hold_r;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  np_mem #(
    .DEPTH (MAX_LEN),
    .WIDTH (VALUE_BITS)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (a_r),
    .rd_addr_b (b_r),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  always_comb begin
    cnt_nxt       = cnt_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    hold_nxt      = hold_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_acc && room) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (step_en) begin
      case (cw.a_op)
        A_N2:    a_nxt = n2;
        A_ZERO:  a_nxt = '0;
        A_DEC:   a_nxt = a_r - IW'(1);
        A_INC:   a_nxt = a_r + IW'(1);
        default: a_nxt = a_r;
      endcase
      case (cw.b_op)
        B_N1:    b_nxt = n1;
        B_DEC:   b_nxt = b_r - IW'(1);
        default: b_nxt = b_r;
      endcase
      if (cw.w_op == W_AB) begin
        hold_nxt = rd_a;
      end
      if (cw.emit) begin
        out_nxt.value_res = 8'(rd_a);
        out_nxt.last_res  = flags.a_last;
        out_valid_nxt     = 1'b1;
      end
      if (cw.finish) begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/np_rom.sv
// Microcode table: one control word per program step.
module np_rom (
  input  logic [np_pkg::PC_W-1:0] pc,
  output np_pkg::np_cw_t          cw
);
  import np_pkg::*;

  function automatic np_cw_t mk(np_cond_t c, logic [PC_W-1:0] t, np_aop_t a, np_bop_t b,
                                np_wop_t w, logic e, logic f);
    np_cw_t r;
    r.cond   = c;
    r.tgt    = t;
    r.a_op   = a;
    r.b_op   = b;
    r.w_op   = w;
    r.emit   = e;
    r.finish = f;
    return r;
  endfunction

  always_comb begin
    case (pc)
      // scan for the pivot from the right
      S_START:  cw = mk(C_SHORT,   S_EMIT0,  A_N2,   B_N1,   W_NONE, 1'b0, 1'b0);
      S_SWAIT:  cw = mk(C_NEXT,    S_START,  A_KEEP, B_KEEP, W_NONE, 1'b0, 1'b0);
      S_SCMP:   cw = mk(C_ALTB,    S_FOUND,  A_KEEP, B_KEEP, W_NONE, 1'b0, 1'b0);
      S_SZERO:  cw = mk(C_AZERO,   S_REVALL, A_KEEP, B_KEEP, W_NONE, 1'b0, 1'b0);
      S_SDEC:   cw = mk(C_ALWAYS,  S_SWAIT,  A_DEC,  B_DEC,  W_NONE, 1'b0, 1'b0);
      S_REVALL: cw = mk(C_ALWAYS,  S_RCHK,   A_KEEP, B_N1,   W_NONE, 1'b0, 1'b0);
      // search the successor from the right
      S_FOUND:  cw = mk(C_NEXT,    S_START,  A_KEEP, B_N1,   W_NONE, 1'b0, 1'b0);
      S_FWAIT:  cw = mk(C_NEXT,    S_START,  A_KEEP, B_KEEP, W_NONE, 1'b0, 1'b0);
      S_FCMP:   cw = mk(C_ALTB,    S_SWAP1,  A_KEEP, B_KEEP, W_NONE, 1'b0, 1'b0);
      S_FDEC:   cw = mk(C_ALWAYS,  S_FWAIT,  A_KEEP, B_DEC,  W_NONE, 1'b0, 1'b0);
      S_SWAP1:  cw = mk(C_NEXT,    S_START,  A_KEEP, B_KEEP, W_AB,   1'b0, 1'b0);
      S_SWAP2:  cw = mk(C_NEXT,    S_START,  A_INC,  B_N1,   W_BH,   1'b0, 1'b0);
      // reverse the suffix
      S_RCHK:   cw = mk(C_AGEB,    S_EMIT0,  A_KEEP, B_KEEP, W_NONE, 1'b0, 1'b0);
      S_RWAIT:  cw = mk(C_NEXT,    S_START,  A_KEEP, B_KEEP, W_NONE, 1'b0, 1'b0);
      S_RW1:    cw = mk(C_NEXT,    S_START,  A_KEEP, B_KEEP, W_AB,   1'b0, 1'b0);
      S_RW2:    cw = mk(C_ALWAYS,  S_RCHK,   A_INC,  B_DEC,  W_BH,   1'b0, 1'b0);
      // stream the result
      S_EMIT0:  cw = mk(C_NEXT,    S_START,  A_ZERO, B_KEEP, W_NONE, 1'b0, 1'b0);
      S_EWAIT:  cw = mk(C_NEXT,    S_START,  A_KEEP, B_KEEP, W_NONE, 1'b0, 1'b0);
      S_EOUT:   cw = mk(C_OUTWAIT, S_START,  A_KEEP, B_KEEP, W_NONE, 1'b1, 1'b0);
      S_ECHK:   cw = mk(C_ALAST,   S_FINISH, A_KEEP, B_KEEP, W_NONE, 1'b0, 1'b0);
      S_EINC:   cw = mk(C_ALWAYS,  S_EWAIT,  A_INC,  B_KEEP, W_NONE, 1'b0, 1'b0);
      S_FINISH: cw = mk(C_ALWAYS,  S_START,  A_KEEP, B_KEEP, W_NONE, 1'b0, 1'b1);
      default:  cw = mk(C_ALWAYS,  S_FINISH, A_KEEP, B_KEEP, W_NONE, 1'b0, 1'b0);
    endcase
  end

endmodule

>>> hw/rtl/np_mem.sv
// Element store: one write port, two registered read ports.
module np_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> hw/rtl/np_seq.sv
// Microcode sequencer: step counter, jump conditions and busy flag.
module np_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  np_pkg::np_cw_t          cw,
  input  np_pkg::np_flags_t       flags,
  output logic [np_pkg::PC_W-1:0] pc,
  output logic                    busy,
  output logic                    step_en
);
  import np_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  logic            jump;
  logic            hold;

  always_comb begin
    case (cw.cond)
      C_NEXT:    jump = 1'b0;
      C_ALWAYS:  jump = 1'b1;
      C_SHORT:   jump = flags.short_seq;
      C_ALTB:    jump = flags.rd_lt;
      C_AZERO:   jump = flags.a_zero;
      C_AGEB:    jump = flags.a_ge_b;
      C_ALAST:   jump = flags.a_last;
      C_OUTWAIT: jump = 1'b0;
      default:   jump = 1'b0;
    endcase
  end

  assign hold    = (cw.cond == C_OUTWAIT) && flags.out_busy;
  assign step_en = busy_r && !hold;

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = S_START;
      busy_nxt = 1'b1;
    end else if (step_en) begin
      pc_nxt = jump ? cw.tgt : pc_r + PC_W'(1);
      if (cw.finish) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= S_START;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign pc   = pc_r;
  assign busy = busy_r;

endmodule

>>> hw/rtl/np_check.sv
// Port-level checks for the permutation block, bound to the top level.
module np_check (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input np_pkg::np_in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input np_pkg::np_out_t out_data
);
  import np_pkg::*;

  a_last_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("word with last taken but input not stalled");

  a_load_keeps_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.last |=> !in_stall)
    else $error("input stalled while loading");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_stall)
    else $error("result word appeared outside processing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

endmodule

bind next_permutation np_check u_np_check (.*);

>>> sim/tb_next_permutation.sv
// Testbench for next_permutation: random and directed sequences checked against a permutation model.
module tb_next_permutation;
  import np_pkg::*;

  localparam int MAX_LEN        = 16;
  localparam int RANDOM_WORDS   = 205;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  typedef enum int {
    FILL_RANDOM,
    FILL_REPEAT,
    FILL_FALLING,
    FILL_EXTREME
  } fill_t;

  class perm_scoreboard;
    logic [7:0] seq_store [MAX_LEN];
    int         held;
    np_out_t    expected_words [$];
    int         errors;

    function new();
      held = 0;
      errors = 0;
    endfunction

    function void flip_range(int lo, int hi);
      logic [7:0] t;
      while (lo < hi) begin
        t = seq_store[lo];
        seq_store[lo] = seq_store[hi];
        seq_store[hi] = t;
        lo++;
        hi--;
      end
    endfunction

    function void advance_perm();
      int         p;
      int         j;
      bit         found;
      logic [7:0] t;
      found = 1'b0;
      if (held < 2) return;
      p = held - 1;
      while (p > 0) begin
        p--;
        if (seq_store[p] < seq_store[p + 1]) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        flip_range(0, held - 1);
        return;
      end
      j = held - 1;
      while (j > p && seq_store[j] <= seq_store[p]) j--;
      t = seq_store[p];
      seq_store[p] = seq_store[j];
      seq_store[j] = t;
      flip_range(p + 1, held - 1);
    endfunction

    function void note_word(np_in_t w);
      np_out_t r;
      int      k;
      if (held < MAX_LEN) begin
        seq_store[held] = w.value;
        held++;
      end
      if (w.last) begin
        advance_perm();
        for (k = 0; k < held; k++) begin
          r.value_res = seq_store[k];
          r.last_res  = (k == held - 1);
          expected_words.push_back(r);
        end
        held = 0;
      end
    endfunction

    function void check_word(np_out_t got);
      np_out_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: value_res %0d last_res %0d",
               got.value_res, got.last_res);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.value_res !== want.value_res) begin
        $error("value_res: expected %0d, got %0d", want.value_res, got.value_res);
        errors++;
      end
      if (got.last_res !== want.last_res) begin
        $error("last_res: expected %0d, got %0d", want.last_res, got.last_res);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  np_in_t  in_data   = '0;
  logic    out_stall = 1'b0;
  logic    in_stall;
  logic    out_valid;
  np_out_t out_data;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles   = 0;

  logic [7:0]     seq_buf [64];
  perm_scoreboard sb;

  next_permutation #(
    .MAX_LEN   (MAX_LEN),
    .VALUE_BITS(8)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_data);
      if (out_valid && !out_stall) sb.check_word(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_word(input logic [7:0] v, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data.value <= v;
    in_data.last  <= lst;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic send_seq(input int len);
    for (int i = 0; i < len; i++) send_word(seq_buf[i], i == len - 1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int         len;
    int         kind;
    int         counted;
    int         phase;
    fill_t      fill;
    logic [7:0] v;

    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 25;
    recv_idle_pct = 45;

    seq_buf[0] = 8'hFF;
    send_seq(1);
    seq_buf[0] = 8'h00;
    seq_buf[1] = 8'hFF;
    send_seq(2);
    seq_buf[0] = 8'hFF;
    seq_buf[1] = 8'hFF;
    seq_buf[2] = 8'h00;
    send_seq(3);
    seq_buf[0] = 8'h01;
    seq_buf[1] = 8'h02;
    seq_buf[2] = 8'h02;
    send_seq(3);
    // hold the sender until all results are back
    drain_results();
    for (int i = 0; i < MAX_LEN; i++) seq_buf[i] = 8'(i * 15 + (i % 3) * 7);
    seq_buf[MAX_LEN] = 8'hAA;
    send_seq(MAX_LEN + 1);

    counted = 0;
    phase   = 0;
    while (counted < RANDOM_WORDS) begin
      if (phase < 2 && counted >= (phase + 1) * RANDOM_WORDS / 3) begin
        drain_results();
        phase++;
        if (phase == 1) begin
          send_idle_pct = 45;
          recv_idle_pct = 25;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      end
      kind = $urandom_range(19);
      if (kind == 0) begin
        len = $urandom_range(17, 20);
      end else if (kind == 1) begin
        len = MAX_LEN;
      end else if (kind < 10) begin
        len = $urandom_range(1, 4);
      end else begin
        len = $urandom_range(2, 8);
      end
      fill = fill_t'($urandom_range(3));
      v    = 8'($urandom_range(255));
      for (int i = 0; i < len; i++) begin
        case (fill)
          FILL_RANDOM: begin
            seq_buf[i] = 8'($urandom_range(255));
          end
          FILL_REPEAT: begin
            seq_buf[i] = v ^ 8'($urandom_range(3));
          end
          FILL_FALLING: begin
            seq_buf[i] = v;
            if (v > 20) v = v - 8'($urandom_range(20));
          end
          default: begin
            seq_buf[i] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
          end
        endcase
      end
      send_seq(len);
      counted += len;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
